// File: hdl/reb_pkg.sv
// Package with shared types, register indexes and helpers for the encoder/button qualifier.
package reb_pkg;

  // Configuration register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TICKS_W    = 16;
  localparam int COUNT_W    = 5;
  localparam int POS_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_LOCKOUT    = 2'd1,
    REG_MENU_COUNT = 2'd2,
    REG_INPUT_CNT  = 2'd3
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [TICKS_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [TICKS_W-1:0] LOCKOUT_RST    = 16'd300;
  localparam logic [COUNT_W-1:0] MENU_COUNT_RST = 5'd4;
  localparam logic [COUNT_W-1:0] INPUT_CNT_RST  = 5'd2;

  // Wrapping index advance: mod 16, then back to zero at or above count
  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                               input logic [COUNT_W-1:0] count);
    logic [POS_W-1:0] nxt;
    nxt = pos + POS_W'(1);
    if ({1'b0, nxt} >= count) begin
      nxt = '0;
    end
    return nxt;
  endfunction

endpackage

// File: hdl/rotary_encoder_button_qualifier.sv
// Top level: rotary encoder direction and push switch short/long press qualifier.
// An accepted pin sample's result is registered in the output register for the next cycle.
// Throughput: one sample per cycle; the output register lets a new request in
// whenever it is empty or its result is being taken in the same cycle.
// Reset (rst, synchronous): encoder levels idle high, switch released, timers,
// latches and indexes zero, registers back to 1000/300/4/2, output empty.
module rotary_encoder_button_qualifier #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [reb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [reb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Pin sample channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             pin_a,
  input  logic                             pin_b,
  input  logic                             pin_switch,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             step_forward,
  output logic                             step_backward,
  output logic                             long_press,
  output logic                             short_press,
  output logic                             ui_update,
  output logic                             ui_activity,
  output logic [reb_pkg::POS_W-1:0]        menu_index,
  output logic [reb_pkg::POS_W-1:0]        input_index
);
  import reb_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > TICKS_W) ? TIMER_WIDTH : TICKS_W;
  localparam logic [TIMER_WIDTH-1:0] HOLD_MAX = '1;

  // Configuration registers
  logic [TICKS_W-1:0] long_press_ticks;
  logic [TICKS_W-1:0] lockout_ticks;
  logic [COUNT_W-1:0] menu_count;
  logic [COUNT_W-1:0] input_count;

  // Qualifier state
  logic                   last_a, last_b, last_switch;
  logic                   dir_fwd_latch, dir_back_latch;
  logic [TIMER_WIDTH-1:0] hold_timer;
  logic                   long_latched;
  logic [TICKS_W-1:0]     lockout_timer;
  logic [POS_W-1:0]       menu_pos, input_pos;

  logic                   last_a_next, last_b_next, last_switch_next;
  logic                   dir_fwd_latch_next, dir_back_latch_next;
  logic [TIMER_WIDTH-1:0] hold_timer_next;
  logic                   long_latched_next;
  logic [TICKS_W-1:0]     lockout_timer_next;
  logic [POS_W-1:0]       menu_pos_next, input_pos_next;
  logic                   fwd, back, lp, sp, upd, act;

  logic in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RST;
      lockout_ticks    <= LOCKOUT_RST;
      menu_count       <= MENU_COUNT_RST;
      input_count      <= INPUT_CNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LONG_PRESS: long_press_ticks <= cfg_data;
        REG_LOCKOUT:    lockout_ticks    <= cfg_data;
        REG_MENU_COUNT: menu_count       <= cfg_data[COUNT_W-1:0];
        REG_INPUT_CNT:  input_count      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // One tick of encoder and switch handling
  always_comb begin
    last_a_next         = last_a;
    last_b_next         = last_b;
    last_switch_next    = last_switch;
    dir_fwd_latch_next  = dir_fwd_latch;
    dir_back_latch_next = dir_back_latch;
    long_latched_next   = long_latched;
    lockout_timer_next  = lockout_timer;
    menu_pos_next       = menu_pos;
    input_pos_next      = input_pos;
    fwd = 1'b0; back = 1'b0; lp = 1'b0; sp = 1'b0; upd = 1'b0; act = 1'b0;

    // encoder edges latch a direction
    if (pin_a != last_a) begin
      last_a_next = pin_a;
      if (pin_a && !pin_b) begin
        dir_back_latch_next = 1'b1;
        dir_fwd_latch_next  = 1'b0;
      end
    end
    if (pin_b != last_b) begin
      last_b_next = pin_b;
      if (!pin_a && pin_b) begin
        dir_back_latch_next = 1'b0;
        dir_fwd_latch_next  = 1'b1;
      end
    end

    // saturating hold timer
    hold_timer_next = (hold_timer == HOLD_MAX) ? hold_timer : hold_timer + TIMER_WIDTH'(1);

    if (lockout_timer != '0) begin
      lockout_timer_next = lockout_timer - TICKS_W'(1);
    end else begin
      fwd = dir_fwd_latch_next && !dir_back_latch_next;
      back = dir_back_latch_next && !dir_fwd_latch_next;
      act = fwd || back;
      dir_fwd_latch_next  = 1'b0;
      dir_back_latch_next = 1'b0;

      // long press, once per press
      if (!pin_switch) begin
        if ((CMP_W'(hold_timer_next) > CMP_W'(long_press_ticks)) && !long_latched) begin
          long_latched_next = 1'b1;
          input_pos_next    = advance(input_pos, input_count);
          lp = 1'b1; upd = 1'b1; act = 1'b1;
        end
      end else begin
        hold_timer_next = '0;
      end

      // switch level change; release without long press is a short press
      if (pin_switch != last_switch) begin
        last_switch_next = pin_switch;
        upd = 1'b1;
        hold_timer_next = '0;
        if (long_latched_next) begin
          long_latched_next = 1'b0;
        end else if (pin_switch) begin
          menu_pos_next      = advance(menu_pos, menu_count);
          sp = 1'b1; act = 1'b1;
          lockout_timer_next = lockout_ticks;
        end
      end
    end
  end

  // State update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_a         <= 1'b1;
      last_b         <= 1'b1;
      last_switch    <= 1'b1;
      dir_fwd_latch  <= 1'b0;
      dir_back_latch <= 1'b0;
      hold_timer     <= '0;
      long_latched   <= 1'b0;
      lockout_timer  <= '0;
      menu_pos       <= '0;
      input_pos      <= '0;
    end else if (in_accept) begin
      last_a         <= last_a_next;
      last_b         <= last_b_next;
      last_switch    <= last_switch_next;
      dir_fwd_latch  <= dir_fwd_latch_next;
      dir_back_latch <= dir_back_latch_next;
      hold_timer     <= hold_timer_next;
      long_latched   <= long_latched_next;
      lockout_timer  <= lockout_timer_next;
      menu_pos       <= menu_pos_next;
      input_pos      <= input_pos_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      step_forward  <= fwd;
      step_backward <= back;
      long_press    <= lp;
      short_press   <= sp;
      ui_update     <= upd;
      ui_activity   <= act;
      menu_index    <= menu_pos_next;
      input_index   <= input_pos_next;
    end
  end

`ifndef SYNTHESIS
  // Both directions never fire together
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(step_forward && step_backward))
    else $error("forward and backward step in one result");

  // A short and a long press never share a tick
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(short_press && long_press))
    else $error("short and long press in one result");

  // Activity covers every pulse; a press always flags an update
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ui_activity == (step_forward || step_backward || long_press || short_press))
                  && (!(short_press || long_press) || ui_update))
    else $error("activity or update flag inconsistent with pulses");

  // A tick taken during the lockout yields no pulses
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && lockout_timer != '0) |=>
      !(step_forward || step_backward || long_press || short_press))
    else $error("pulse produced during lockout");
`endif

endmodule
